FILE: rtl/breakpoint_address_table_defines.svh
// assertion macros for the breakpoint address table
`ifndef BREAKPOINT_ADDRESS_TABLE_DEFINES_SVH
`define BREAKPOINT_ADDRESS_TABLE_DEFINES_SVH

// checked at every clock edge outside reset
`define BAT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked at every clock edge, reset included
`define BAT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: rtl/bat_pkg.sv
// types and codes shared by the breakpoint address table files
`timescale 1ns / 1ps
`default_nettype none

package bat_pkg;

   // request function codes
   localparam logic [2:0] FUNC_SET     = 3'd0;
   localparam logic [2:0] FUNC_REMOVE  = 3'd1;
   localparam logic [2:0] FUNC_ENABLE  = 3'd2;
   localparam logic [2:0] FUNC_DISABLE = 3'd3;
   localparam logic [2:0] FUNC_TRAP    = 3'd4;
   localparam logic [2:0] FUNC_LIST    = 3'd5;

   // response status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   // code patch actions
   localparam logic [1:0] PATCH_NONE    = 2'd0;
   localparam logic [1:0] PATCH_TRAP    = 2'd1;
   localparam logic [1:0] PATCH_RESTORE = 2'd2;

   localparam logic [31:0] NUMBER_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] addr;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] entry_number;
      logic [63:0] entry_address;
      logic        entry_enabled;
      logic [1:0]  code_patch;
      logic        last;
   } rsp_type;

   // one stored table entry
   typedef struct packed {
      logic [63:0] addr;
      logic [31:0] number;
      logic        enabled;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_LIST_RD,
      ST_LIST_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/bat_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bat_ram #(
   parameter int WIDTH = 97,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/breakpoint_address_table.sv
// breakpoint address table: entry ram, fill count, number counter and sequencer
// search: each entry visited is read, then compared with the key; a hit strobes the
// result, and a miss over all entries strobes it and frees busy together
// remove then moves each later entry down with a read and a write before busy drops
// list: each entry is read, then given as one result; an empty list answers in the cycle after accept
// sync reset empties the table and zeroes the number counter; results cannot stall
`timescale 1ns / 1ps
`default_nettype none

`include "breakpoint_address_table_defines.svh"

module breakpoint_address_table #(
   parameter int MAX_ENTRIES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire bat_pkg::req_type req_payload,
   output logic                  rsp_strobe,
   output bat_pkg::rsp_type      rsp_payload
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = $bits(bat_pkg::entry_type);

   bat_pkg::state_type state_ff, state_in;
   logic [2:0]         func_ff, func_in;
   logic [63:0]        key_ff, key_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [31:0]        num_ff, num_in;
   bat_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   bat_pkg::entry_type ram_wdata;
   logic               ram_re;
   logic [AW-1:0]      ram_raddr;
   bat_pkg::entry_type ram_rdata;

   logic               accept;
   logic               hit;
   logic               cnt_full;
   logic               last_idx;
   logic [CW-1:0]      idx_next;
   logic [31:0]        new_num;

   // entry storage
   bat_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (EW'(ram_wdata)),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // shared decode
   assign busy     = (state_ff != bat_pkg::ST_IDLE);
   assign accept   = start && !busy;
   assign hit      = (ram_rdata.addr == key_ff);
   assign cnt_full = (cnt_ff == CW'(MAX_ENTRIES));
   assign idx_next = idx_ff + CW'(1);
   assign last_idx = (idx_next == cnt_ff);
   assign new_num  = (num_ff == bat_pkg::NUMBER_MAX) ? num_ff : num_ff + 32'd1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bat_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.func)
                  bat_pkg::FUNC_SET, bat_pkg::FUNC_REMOVE, bat_pkg::FUNC_ENABLE,
                  bat_pkg::FUNC_DISABLE, bat_pkg::FUNC_TRAP: begin
                     state_in = bat_pkg::ST_SCAN_RD;
                  end
                  bat_pkg::FUNC_LIST: begin
                     state_in = (cnt_ff == '0) ? bat_pkg::ST_IDLE : bat_pkg::ST_LIST_RD;
                  end
                  default: begin
                     state_in = bat_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         bat_pkg::ST_SCAN_RD: begin
            state_in = (idx_ff == cnt_ff) ? bat_pkg::ST_IDLE : bat_pkg::ST_SCAN_CHK;
         end
         bat_pkg::ST_SCAN_CHK: begin
            if (!hit) begin
               state_in = bat_pkg::ST_SCAN_RD;
            end else if (func_ff == bat_pkg::FUNC_REMOVE) begin
               state_in = bat_pkg::ST_SHIFT_RD;
            end else begin
               state_in = bat_pkg::ST_IDLE;
            end
         end
         bat_pkg::ST_SHIFT_RD: begin
            state_in = last_idx ? bat_pkg::ST_IDLE : bat_pkg::ST_SHIFT_WR;
         end
         bat_pkg::ST_SHIFT_WR: begin
            state_in = bat_pkg::ST_SHIFT_RD;
         end
         bat_pkg::ST_LIST_RD: begin
            state_in = bat_pkg::ST_LIST_OUT;
         end
         bat_pkg::ST_LIST_OUT: begin
            state_in = last_idx ? bat_pkg::ST_IDLE : bat_pkg::ST_LIST_RD;
         end
         default: begin
            state_in = bat_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath, ram control and result
   always_comb begin
      func_in      = func_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      num_in       = num_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff[AW-1:0];
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff[AW-1:0];

      unique case (state_ff)
         bat_pkg::ST_IDLE: begin
            if (accept) begin
               func_in = req_payload.func;
               key_in  = (req_payload.func == bat_pkg::FUNC_TRAP) ?
                         req_payload.addr - 64'd1 : req_payload.addr;
               idx_in  = '0;
               // empty list answers at once
               if (req_payload.func == bat_pkg::FUNC_LIST && cnt_ff == '0) begin
                  rsp_in       = '0;
                  rsp_in.status = bat_pkg::STATUS_EMPTY;
                  rsp_in.last  = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         bat_pkg::ST_SCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               // search missed
               rsp_in.entry_address = key_ff;
               rsp_in.last          = 1'b1;
               rsp_valid_in         = 1'b1;
               if (func_ff == bat_pkg::FUNC_SET && !cnt_full) begin
                  ram_we            = 1'b1;
                  ram_waddr         = cnt_ff[AW-1:0];
                  ram_wdata.addr    = key_ff;
                  ram_wdata.number  = new_num;
                  ram_wdata.enabled = 1'b1;
                  cnt_in            = cnt_ff + CW'(1);
                  num_in            = new_num;
                  rsp_in.status        = bat_pkg::STATUS_OK;
                  rsp_in.entry_number  = new_num;
                  rsp_in.entry_enabled = 1'b1;
                  rsp_in.code_patch    = bat_pkg::PATCH_TRAP;
               end else begin
                  rsp_in.status        = (func_ff == bat_pkg::FUNC_SET) ?
                                         bat_pkg::STATUS_FULL : bat_pkg::STATUS_NOT_FOUND;
                  rsp_in.entry_number  = '0;
                  rsp_in.entry_enabled = 1'b0;
                  rsp_in.code_patch    = bat_pkg::PATCH_NONE;
               end
            end else begin
               ram_re = 1'b1;
            end
         end
         bat_pkg::ST_SCAN_CHK: begin
            if (hit) begin
               rsp_in.status        = bat_pkg::STATUS_OK;
               rsp_in.entry_number  = ram_rdata.number;
               rsp_in.entry_address = key_ff;
               rsp_in.entry_enabled = ram_rdata.enabled;
               rsp_in.code_patch    = bat_pkg::PATCH_NONE;
               rsp_in.last          = 1'b1;
               rsp_valid_in         = 1'b1;
               unique case (func_ff)
                  bat_pkg::FUNC_SET, bat_pkg::FUNC_ENABLE: begin
                     ram_we               = 1'b1;
                     ram_wdata.enabled    = 1'b1;
                     rsp_in.entry_enabled = 1'b1;
                     rsp_in.code_patch    = bat_pkg::PATCH_TRAP;
                  end
                  bat_pkg::FUNC_DISABLE: begin
                     ram_we               = 1'b1;
                     ram_wdata.enabled    = 1'b0;
                     rsp_in.entry_enabled = 1'b0;
                     rsp_in.code_patch    = bat_pkg::PATCH_RESTORE;
                  end
                  bat_pkg::FUNC_REMOVE: begin
                     rsp_in.code_patch = bat_pkg::PATCH_RESTORE;
                  end
                  default: begin
                     rsp_in.code_patch = bat_pkg::PATCH_NONE;
                  end
               endcase
            end else begin
               idx_in = idx_next;
            end
         end
         bat_pkg::ST_SHIFT_RD: begin
            // close the gap left by the removed entry
            if (last_idx) begin
               cnt_in = cnt_ff - CW'(1);
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_next[AW-1:0];
            end
         end
         bat_pkg::ST_SHIFT_WR: begin
            ram_we = 1'b1;
            idx_in = idx_next;
         end
         bat_pkg::ST_LIST_RD: begin
            ram_re = 1'b1;
         end
         bat_pkg::ST_LIST_OUT: begin
            rsp_in.status        = bat_pkg::STATUS_OK;
            rsp_in.entry_number  = ram_rdata.number;
            rsp_in.entry_address = ram_rdata.addr;
            rsp_in.entry_enabled = ram_rdata.enabled;
            rsp_in.code_patch    = bat_pkg::PATCH_NONE;
            rsp_in.last          = last_idx;
            rsp_valid_in         = 1'b1;
            idx_in               = idx_next;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bat_pkg::ST_IDLE;
         cnt_ff       <= '0;
         num_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         num_ff       <= num_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff <= func_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   `BAT_ASSERT(a_cnt_bound, cnt_ff <= CW'(MAX_ENTRIES), "fill count above table depth")
   `BAT_ASSERT(a_strobe_cause, rsp_strobe |-> $past(busy || start), "result without transaction")
   `BAT_ASSERT(a_write_busy, ram_we |-> busy, "table write while idle")
   `BAT_ASSERT(a_num_mono, !$past(reset) |-> (num_ff >= $past(num_ff)), "number counter went back")

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// self-checking testbench for the breakpoint address table
`timescale 1ns / 1ps

module testbench;

   localparam int TABLE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 280;
   localparam int POOL_SIZE = 24;
   localparam int SETTLE_CYCLES = 120;

   // function codes the block ignores
   localparam logic [2:0] FUNC_SPARE_A = 3'd6;
   localparam logic [2:0] FUNC_SPARE_B = 3'd7;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   bat_pkg::req_type req_payload;
   logic             rsp_strobe;
   bat_pkg::rsp_type rsp_payload;

   // shadow of the table and the queue of responses it predicts
   class breakpoint_scoreboard;
      bat_pkg::entry_type shadow_entries[$];
      logic [31:0]        last_number;
      bat_pkg::rsp_type   expected_rsps[$];
      int                 mismatches;

      function new();
         last_number = '0;
         mismatches = 0;
      endfunction

      function int find_entry(logic [63:0] a);
         foreach (shadow_entries[i])
            if (shadow_entries[i].addr == a)
               return i;
         return -1;
      endfunction

      function void push_rsp(logic [1:0] st, logic [31:0] num, logic [63:0] a,
                             logic en, logic [1:0] patch, logic fin);
         bat_pkg::rsp_type r;
         r.status = st;
         r.entry_number = num;
         r.entry_address = a;
         r.entry_enabled = en;
         r.code_patch = patch;
         r.last = fin;
         expected_rsps.push_back(r);
      endfunction

      // predict the responses of one accepted command transaction
      function void note_command(bat_pkg::req_type cmd);
         int                 idx;
         logic [63:0]        look;
         bat_pkg::entry_type e;
         idx = -1;
         case (cmd.func)
            bat_pkg::FUNC_SET: begin
               idx = find_entry(cmd.addr);
               if (idx >= 0) begin
                  e = shadow_entries[idx];
                  e.enabled = 1'b1;
                  shadow_entries[idx] = e;
                  push_rsp(bat_pkg::STATUS_OK, e.number, cmd.addr, 1'b1,
                           bat_pkg::PATCH_TRAP, 1'b1);
               end else if (shadow_entries.size() >= TABLE_DEPTH) begin
                  push_rsp(bat_pkg::STATUS_FULL, '0, cmd.addr, 1'b0,
                           bat_pkg::PATCH_NONE, 1'b1);
               end else begin
                  // number counter sticks at its maximum
                  if (last_number != bat_pkg::NUMBER_MAX)
                     last_number = last_number + 32'd1;
                  e.addr = cmd.addr;
                  e.number = last_number;
                  e.enabled = 1'b1;
                  shadow_entries.push_back(e);
                  push_rsp(bat_pkg::STATUS_OK, e.number, cmd.addr, 1'b1,
                           bat_pkg::PATCH_TRAP, 1'b1);
               end
            end
            bat_pkg::FUNC_REMOVE: begin
               idx = find_entry(cmd.addr);
               if (idx < 0) begin
                  push_rsp(bat_pkg::STATUS_NOT_FOUND, '0, cmd.addr, 1'b0,
                           bat_pkg::PATCH_NONE, 1'b1);
               end else begin
                  e = shadow_entries[idx];
                  push_rsp(bat_pkg::STATUS_OK, e.number, cmd.addr, e.enabled,
                           bat_pkg::PATCH_RESTORE, 1'b1);
                  shadow_entries.delete(idx);
               end
            end
            bat_pkg::FUNC_ENABLE, bat_pkg::FUNC_DISABLE: begin
               idx = find_entry(cmd.addr);
               if (idx < 0) begin
                  push_rsp(bat_pkg::STATUS_NOT_FOUND, '0, cmd.addr, 1'b0,
                           bat_pkg::PATCH_NONE, 1'b1);
               end else begin
                  e = shadow_entries[idx];
                  e.enabled = (cmd.func == bat_pkg::FUNC_ENABLE);
                  shadow_entries[idx] = e;
                  push_rsp(bat_pkg::STATUS_OK, e.number, cmd.addr, e.enabled,
                           e.enabled ? bat_pkg::PATCH_TRAP : bat_pkg::PATCH_RESTORE, 1'b1);
               end
            end
            bat_pkg::FUNC_TRAP: begin
               // the trap address points one past the patched byte
               look = cmd.addr - 64'd1;
               idx = find_entry(look);
               if (idx < 0)
                  push_rsp(bat_pkg::STATUS_NOT_FOUND, '0, look, 1'b0,
                           bat_pkg::PATCH_NONE, 1'b1);
               else
                  push_rsp(bat_pkg::STATUS_OK, shadow_entries[idx].number, look,
                           shadow_entries[idx].enabled, bat_pkg::PATCH_NONE, 1'b1);
            end
            bat_pkg::FUNC_LIST: begin
               if (shadow_entries.size() == 0)
                  push_rsp(bat_pkg::STATUS_EMPTY, '0, '0, 1'b0, bat_pkg::PATCH_NONE, 1'b1);
               else
                  foreach (shadow_entries[i])
                     push_rsp(bat_pkg::STATUS_OK, shadow_entries[i].number,
                              shadow_entries[i].addr, shadow_entries[i].enabled,
                              bat_pkg::PATCH_NONE, i == shadow_entries.size() - 1);
            end
            default: ;
         endcase
      endfunction

      // compare one response transaction with the oldest prediction
      function void check_response(bat_pkg::rsp_type got);
         bat_pkg::rsp_type want;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected response status %0d number %0d address %h",
                        $realtime, got.status, got.entry_number, got.entry_address);
            return;
         end
         want = expected_rsps.pop_front();
         if (got.status !== want.status || got.entry_number !== want.entry_number ||
             got.entry_address !== want.entry_address ||
             got.entry_enabled !== want.entry_enabled ||
             got.code_patch !== want.code_patch || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: mismatch expected st %0d num %0d addr %h en %0d patch %0d last %0d",
                        $realtime, want.status, want.entry_number, want.entry_address,
                        want.entry_enabled, want.code_patch, want.last);
               $display("%0t:              got st %0d num %0d addr %h en %0d patch %0d last %0d",
                        $realtime, got.status, got.entry_number, got.entry_address,
                        got.entry_enabled, got.code_patch, got.last);
            end
         end
      endfunction
   endclass

   breakpoint_scoreboard sb = new();
   logic [63:0] addr_pool[POOL_SIZE];

   breakpoint_address_table #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_response(rsp_payload);
   end

   // present one command and hold it until the block takes it
   task automatic send_command(input logic [2:0] func, input logic [63:0] addr);
      bat_pkg::req_type cmd;
      cmd.func = func;
      cmd.addr = addr;
      @(negedge clock);
      start <= 1'b1;
      req_payload <= cmd;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      sb.note_command(cmd);
   endtask

   // random gap between commands, never when quiet
   task automatic idle_gap(input bit quiet);
      int n;
      n = $urandom_range(1, 8);
      if (!quiet && $urandom_range(0, 99) < 13) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1)
            @(negedge clock);
      end
   endtask

   // hold off until every predicted response has come back
   task automatic drain_responses();
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [63:0] pick_addr();
      if ($urandom_range(0, 9) == 0)
         return {$urandom, $urandom};
      return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   // one random command, weighted toward filling or draining the table
   task automatic random_command(input bit filling, input bit quiet, output bit counted);
      int          r;
      logic [2:0]  func;
      logic [63:0] addr;
      r = $urandom_range(0, 99);
      addr = pick_addr();
      if (filling)
         func = (r < 45) ? bat_pkg::FUNC_SET : (r < 55) ? bat_pkg::FUNC_REMOVE :
                (r < 63) ? bat_pkg::FUNC_ENABLE : (r < 71) ? bat_pkg::FUNC_DISABLE :
                (r < 85) ? bat_pkg::FUNC_TRAP : (r < 96) ? bat_pkg::FUNC_LIST :
                (r < 98) ? FUNC_SPARE_A : FUNC_SPARE_B;
      else
         func = (r < 15) ? bat_pkg::FUNC_SET : (r < 50) ? bat_pkg::FUNC_REMOVE :
                (r < 60) ? bat_pkg::FUNC_ENABLE : (r < 70) ? bat_pkg::FUNC_DISABLE :
                (r < 84) ? bat_pkg::FUNC_TRAP : (r < 96) ? bat_pkg::FUNC_LIST :
                (r < 98) ? FUNC_SPARE_A : FUNC_SPARE_B;
      // most trap lookups point just past a known breakpoint
      if (func == bat_pkg::FUNC_TRAP && $urandom_range(0, 4) != 0)
         addr = addr + 64'd1;
      send_command(func, addr);
      counted = (func != FUNC_SPARE_A && func != FUNC_SPARE_B);
      idle_gap(quiet);
   endtask

   // main stimulus
   initial begin
      int  done;
      bit  counted;
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         addr_pool[i] = {$urandom, $urandom};
      repeat (2)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corner cases
      send_command(bat_pkg::FUNC_LIST, 64'h0);
      send_command(bat_pkg::FUNC_REMOVE, 64'h1000);
      send_command(bat_pkg::FUNC_TRAP, 64'h0);
      send_command(bat_pkg::FUNC_SET, 64'h0);
      send_command(bat_pkg::FUNC_SET, '1);
      send_command(bat_pkg::FUNC_SET, 64'h1000);
      send_command(bat_pkg::FUNC_SET, 64'h1000);
      send_command(bat_pkg::FUNC_TRAP, 64'h1);
      send_command(bat_pkg::FUNC_TRAP, 64'h0);
      send_command(bat_pkg::FUNC_DISABLE, 64'h1000);
      send_command(bat_pkg::FUNC_TRAP, 64'h1001);
      send_command(bat_pkg::FUNC_SET, 64'h1000);
      send_command(bat_pkg::FUNC_DISABLE, 64'h0);
      send_command(bat_pkg::FUNC_ENABLE, 64'h0);
      send_command(bat_pkg::FUNC_ENABLE, 64'h2000);
      send_command(bat_pkg::FUNC_DISABLE, 64'h2000);
      send_command(bat_pkg::FUNC_REMOVE, 64'h0);
      send_command(bat_pkg::FUNC_LIST, 64'h0);
      send_command(FUNC_SPARE_A, 64'h5555_5555_5555_5555);
      send_command(FUNC_SPARE_B, 64'hAAAA_AAAA_AAAA_AAAA);
      send_command(bat_pkg::FUNC_SET, 64'h5555_5555_5555_5555);
      send_command(bat_pkg::FUNC_SET, 64'hAAAA_AAAA_AAAA_AAAA);
      send_command(bat_pkg::FUNC_LIST, 64'h0);
      send_command(bat_pkg::FUNC_REMOVE, '1);
      send_command(bat_pkg::FUNC_REMOVE, 64'h1000);
      drain_responses();

      // fill the table past its capacity, then walk it
      done = 0;
      for (int i = 0; i < TABLE_DEPTH + 2; i++) begin
         send_command(bat_pkg::FUNC_SET, addr_pool[i]);
         idle_gap(1'b0);
         done++;
      end
      send_command(bat_pkg::FUNC_LIST, 64'h0);
      done++;

      // random traffic in alternating fill and drain phases
      while (done < RANDOM_ITEMS) begin
         if (done == 200)
            drain_responses();
         random_command(((done / 50) % 2) == 0, done >= 120 && done < 180, counted);
         if (counted)
            done++;
      end

      // let the last transactions finish
      @(negedge clock);
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_rsps.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_rsps.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
